// ===== rtl/core/pbbw_pkg.sv =====
package pbbw_pkg;

  // Widths of the stream payloads.
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 24;
  localparam int ADDR_W    = 10;

  // Depth of the queue between the classifier and the write sequencer.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified bitmap byte: up to two OR-writes into the framebuffer.
  typedef struct packed {
    logic [7:0] col;
    logic [4:0] page0;
    logic [7:0] bits0;
    logic       valid0;
    logic [4:0] page1;
    logic [7:0] bits1;
    logic       valid1;
  } write_pair_t;

endpackage

// ===== rtl/core/pbbw_front.sv =====
module pbbw_front #(
  parameter int FRAME_COLUMNS = 128,
  parameter int FRAME_ROWS    = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pbbw_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          s_tuser,
  input  logic                          cfg_we,
  input  logic [7:0]                    cfg_wdata,
  output logic                          fq_valid,
  output pbbw_pkg::write_pair_t         fq_entry,
  input  logic                          q_ready
);
  import pbbw_pkg::*;

  logic [7:0] anim_offset;
  logic [7:0] pos_x, pos_y, bmp_width, bmp_height, win_shift, col_index, pix;
  logic [4:0] band;
  logic [7:0] yy, y, top_row, bot_row, end_row, col, d_top, d_bot, mask, bits;
  logic [2:0] shift;
  logic       in_range, col_ok, win_on, skip, top_ok, bot_ok, keep;
  write_pair_t entry;

  // Animation offset register.
  always_ff @(posedge clk) begin
    if (rst) begin
      anim_offset <= 8'd0;
    end else if (cfg_we) begin
      anim_offset <= cfg_wdata;
    end
  end

  // Unpack the input transaction.
  assign pos_x      = s_tdata[7:0];
  assign pos_y      = s_tdata[15:8];
  assign bmp_width  = s_tdata[23:16];
  assign bmp_height = s_tdata[31:24];
  assign win_shift  = s_tdata[39:32];
  assign band       = s_tdata[44:40];
  assign col_index  = s_tdata[52:45];
  assign pix        = s_tdata[60:53];

  // Geometry, all byte coordinates wrap at 256.
  always_comb begin
    in_range = (band < bmp_height[7:3]) && (col_index < bmp_width);
    yy       = pos_y + anim_offset;
    y        = yy - win_shift;
    top_row  = {band, 3'b000} + y;
    bot_row  = top_row + 8'd8;
    end_row  = yy + bmp_height;
    shift    = y[2:0];
    col      = col_index + pos_x;
    col_ok   = {1'b0, col} < 9'(FRAME_COLUMNS);
    win_on   = win_shift != 8'd0;
    skip     = win_on && ((bot_row < yy) || ({1'b0, bot_row} > 9'(FRAME_ROWS)) ||
                          (top_row > end_row));
    top_ok   = {1'b0, top_row} < 9'(FRAME_ROWS);
    bot_ok   = {1'b0, bot_row} < 9'(FRAME_ROWS);
  end

  // Edge mask against the window; shifts of eight or more clear the mask.
  always_comb begin
    d_top = yy - top_row;
    d_bot = bot_row - end_row;
    mask  = 8'hFF;
    if (win_on && (top_row < yy)) begin
      mask = 8'hFF << d_top;
    end else if (win_on && (bot_row > end_row)) begin
      mask = 8'hFF >> d_bot;
    end
    bits = (s_tuser ? ~pix : pix) & mask;
  end

  // Split the byte across pages when the row is not page aligned.
  always_comb begin
    entry.col    = col;
    entry.page0  = top_row[7:3];
    entry.bits0  = bits << shift;
    entry.valid0 = top_ok;
    entry.page1  = bot_row[7:3];
    entry.bits1  = bits >> (4'd8 - {1'b0, shift});
    entry.valid1 = bot_ok && !((shift == 3'd0) && top_ok);
    keep         = in_range && col_ok && !skip && (entry.valid0 || entry.valid1);
  end

  assign s_tready = !fq_valid || q_ready;

  // Stage register in front of the queue; items with no writes are dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      fq_valid <= 1'b0;
    end else if (s_tready) begin
      fq_valid <= s_tvalid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      fq_entry <= entry;
    end
  end

endmodule

// ===== rtl/core/pbbw_queue.sv =====
module pbbw_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pbbw_pkg::write_pair_t in_entry,
  output logic                  out_valid,
  output pbbw_pkg::write_pair_t out_entry,
  input  logic                  out_pop
);
  import pbbw_pkg::*;

  write_pair_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [QPTR_W:0]       count;
  logic                  push, pop;

  assign in_ready  = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_entry = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_entry;
    end
  end

endmodule

// ===== rtl/core/pbbw_back.sv =====
module pbbw_back #(
  parameter int FRAME_COLUMNS = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  pbbw_pkg::write_pair_t          q_entry,
  output logic                           q_pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [pbbw_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tlast
);
  import pbbw_pkg::*;

  localparam int PROD_W = 14;

  logic              second;
  logic              second_next;
  logic              load, emit, last_sel;
  logic [4:0]        page_sel;
  logic [7:0]        bits_sel;
  logic [PROD_W-1:0] addr_full;
  logic [ADDR_W-1:0] write_address;
  logic [7:0]        or_bits;

  assign load = !m_tvalid || m_tready;

  // Pick the next write of the head entry.
  always_comb begin
    emit        = 1'b0;
    q_pop       = 1'b0;
    second_next = second;
    page_sel    = q_entry.page1;
    bits_sel    = q_entry.bits1;
    last_sel    = 1'b1;
    if (q_valid && load) begin
      emit = 1'b1;
      if (!second && q_entry.valid0) begin
        page_sel = q_entry.page0;
        bits_sel = q_entry.bits0;
        last_sel = !q_entry.valid1;
        if (q_entry.valid1) begin
          second_next = 1'b1;
        end else begin
          q_pop = 1'b1;
        end
      end else begin
        q_pop       = 1'b1;
        second_next = 1'b0;
      end
    end
  end

  assign addr_full = PROD_W'(page_sel) * PROD_W'(FRAME_COLUMNS) + PROD_W'(q_entry.col);

  always_ff @(posedge clk) begin
    if (rst) begin
      second   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      second <= second_next;
      if (load) begin
        m_tvalid <= emit;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load && emit) begin
      write_address <= addr_full[ADDR_W-1:0];
      or_bits       <= bits_sel;
      m_tlast       <= last_sel;
    end
  end

  assign m_tdata = {6'd0, or_bits, write_address};

endmodule

// ===== rtl/core/page_bitmap_blit_writer.sv =====
// Page framebuffer bitmap blit writer. Each input transaction carries one
// byte of a page-organized monochrome bitmap (eight vertical pixels) with its
// band, column and the blit geometry; the block answers with zero, one or two
// OR-writes into a page framebuffer, each a byte address and eight bits, the
// final one flagged by m_tlast. A new input is taken every cycle while the
// queue has room; the output gives one write per cycle while m_tready is
// high, so a byte split across two pages takes two writes and the input
// rate then follows from the output port. Inputs pass through the classifier
// stage, queue and output register. The user must write anim_offset through
// cfg_we/cfg_wdata only while no transactions are in flight; unenforced.
module page_bitmap_blit_writer #(
  parameter int FRAME_COLUMNS = 128,
  parameter int FRAME_ROWS    = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [7:0]                     cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pos_x, pos_y, bitmap_width, bitmap_height, window_shift, band_index,
  // column_index, pixel_byte, zero fill
  input  logic [pbbw_pkg::S_TDATA_W-1:0] s_tdata,
  // invert_pixels
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // write_address, or_bits, zero fill
  output logic [pbbw_pkg::M_TDATA_W-1:0] m_tdata,
  // last_of_run
  output logic                           m_tlast
);
  import pbbw_pkg::*;

  logic        fq_valid, q_ready, q_valid, q_pop;
  write_pair_t fq_entry, q_entry;

  // Classifier: geometry, clipping and masking.
  pbbw_front #(
    .FRAME_COLUMNS(FRAME_COLUMNS),
    .FRAME_ROWS   (FRAME_ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .fq_valid (fq_valid),
    .fq_entry (fq_entry),
    .q_ready  (q_ready)
  );

  // Queue between classifier and write sequencer.
  pbbw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fq_valid),
    .in_ready (q_ready),
    .in_entry (fq_entry),
    .out_valid(q_valid),
    .out_entry(q_entry),
    .out_pop  (q_pop)
  );

  // Write sequencer and output register.
  pbbw_back #(
    .FRAME_COLUMNS(FRAME_COLUMNS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  // Only items with at least one write enter the queue.
  assert property (@(posedge clk) disable iff (rst)
    fq_valid |-> (fq_entry.valid0 || fq_entry.valid1))
    else $error("queued item carries no write");

  // The second write of a split byte follows right after the first is taken.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("second write of a pair did not follow");

  // A classified item waiting for queue space is held unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (fq_valid && !q_ready) |=> (fq_valid && $stable(fq_entry)))
    else $error("classified item changed while stalled");

  // The input stalls only while the classifier stage holds an item.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> fq_valid)
    else $error("input stalled with empty classifier stage");

endmodule
